// ===== rtl/core/slcd_pkg.sv =====
// Package for the sync/length/checksum deframer.
// Holds the result kind codes, sync bytes and field widths.
// No dependencies.
`default_nettype none

package slcd_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CmdW   = 16;
    localparam int unsigned CountW = 22;
    localparam int unsigned KindW  = 2;
    localparam int unsigned SumW   = 16;

    localparam logic [ByteW-1:0] SYNC_FIRST  = 8'hFF;
    localparam logic [ByteW-1:0] SYNC_SECOND = 8'hFE;

    localparam logic [CountW-1:0] MAX_LENGTH_RESET = 22'd4096000;
    localparam logic [CountW-1:0] HEADER_BYTES     = 22'd4;

    typedef enum logic [KindW-1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_SUM  = 2'd2,
        KIND_BAD_LEN  = 2'd3
    } kind_t;

endpackage

`default_nettype wire

// ===== rtl/core/sync_length_checksum_deframer.sv =====
// Top level of the sync/length/checksum deframer.
// Depends on slcd_pkg for kind codes, sync bytes and widths.
//
//   Channel  Ports                                  Direction  Handshake
//   input    s_rx_byte                              in         s_valid / s_ready
//   result   m_kind, m_data_byte, m_command,
//            m_payload_count                        out        m_valid / m_ready
//   config   cfg_wr_en, cfg_wr_data (max_length)    in         write enable only
//
// Each byte is held in the input register and then parsed into the result register,
// so a byte is taken every cycle while the result channel does not stall.
// A result is valid once its byte has passed the input register and the result register.
// The synchronous reset returns the parser to the sync hunt and max_length to 4096000.
// A stalled result holds the input register, which then backs up s_ready.
`default_nettype none

module sync_length_checksum_deframer
    import slcd_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [ByteW-1:0]  s_rx_byte,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [KindW-1:0]       m_kind,
    output logic [ByteW-1:0]       m_data_byte,
    output logic [CmdW-1:0]        m_command,
    output logic [CountW-1:0]      m_payload_count,
    input  wire logic              cfg_wr_en,
    input  wire logic [CountW-1:0] cfg_wr_data
);

    typedef enum logic [3:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_CMD0,
        PH_CMD1,
        PH_PAYLOAD,
        PH_SUM0,
        PH_SUM1
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [CountW-1:0]   max_length_reg;
    logic                in_valid_reg;
    logic [ByteW-1:0]    in_byte_reg;
    logic [23:0]         len_low_reg, len_low_next;
    logic [CountW-1:0]   total_reg, total_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic [CmdW-1:0]     cmd_reg, cmd_next;
    logic [SumW-1:0]     sum_reg, sum_next;
    logic [ByteW-1:0]    sum_low_reg, sum_low_next;
    logic                out_valid_reg;
    kind_t               out_kind_reg;
    logic [ByteW-1:0]    out_data_reg;
    logic [CmdW-1:0]     out_cmd_reg;
    logic [CountW-1:0]   out_count_reg;

    logic                advance;
    logic                res_valid;
    kind_t               res_kind;
    logic [ByteW-1:0]    res_data;
    logic [CmdW-1:0]     res_cmd;
    logic [CountW-1:0]   res_count;
    logic                len_bad;
    logic [CountW-1:0]   count_inc;
    logic [SumW-1:0]     rx_sum;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign len_bad = (in_byte_reg != '0) || (len_low_reg[23:CountW] != '0)
                   || (len_low_reg[CountW-1:0] < HEADER_BYTES)
                   || (len_low_reg[CountW-1:0] > max_length_reg);
    assign count_inc = count_reg + 1'b1;
    assign rx_sum    = {in_byte_reg, sum_low_reg};

    always_comb begin
        phase_next   = phase_reg;
        len_low_next = len_low_reg;
        total_next   = total_reg;
        count_next   = count_reg;
        cmd_next     = cmd_reg;
        sum_next     = sum_reg;
        sum_low_next = sum_low_reg;
        res_valid    = 1'b0;
        res_kind     = KIND_PAYLOAD;
        res_data     = '0;
        res_cmd      = '0;
        res_count    = '0;
        unique case (phase_reg)
            PH_HUNT0: begin
                if (in_byte_reg == SYNC_FIRST) begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_HUNT1: begin
                if (in_byte_reg == SYNC_SECOND) begin
                    phase_next = PH_LEN0;
                end else if (in_byte_reg != SYNC_FIRST) begin
                    phase_next = PH_HUNT0;
                end
            end
            PH_LEN0: begin
                len_low_next[7:0] = in_byte_reg;
                phase_next        = PH_LEN1;
            end
            PH_LEN1: begin
                len_low_next[15:8] = in_byte_reg;
                phase_next         = PH_LEN2;
            end
            PH_LEN2: begin
                len_low_next[23:16] = in_byte_reg;
                phase_next          = PH_LEN3;
            end
            PH_LEN3: begin
                total_next = len_low_reg[CountW-1:0] - HEADER_BYTES;
                if (len_bad) begin
                    phase_next = PH_HUNT0;
                    res_valid  = 1'b1;
                    res_kind   = KIND_BAD_LEN;
                end else begin
                    phase_next = PH_CMD0;
                end
            end
            PH_CMD0: begin
                cmd_next[7:0] = in_byte_reg;
                phase_next    = PH_CMD1;
            end
            PH_CMD1: begin
                cmd_next[15:8] = in_byte_reg;
                count_next     = '0;
                sum_next       = '0;
                phase_next     = (total_reg == '0) ? PH_SUM0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                count_next = count_inc;
                sum_next   = sum_reg + {{(SumW-ByteW){1'b0}}, in_byte_reg};
                if (count_inc >= total_reg) begin
                    phase_next = PH_SUM0;
                end
                res_valid = 1'b1;
                res_kind  = KIND_PAYLOAD;
                res_data  = in_byte_reg;
                res_cmd   = cmd_reg;
                res_count = count_inc;
            end
            PH_SUM0: begin
                sum_low_next = in_byte_reg;
                phase_next   = PH_SUM1;
            end
            PH_SUM1: begin
                phase_next = PH_HUNT0;
                res_valid  = 1'b1;
                res_kind   = (rx_sum == sum_reg) ? KIND_GOOD : KIND_BAD_SUM;
                res_cmd    = cmd_reg;
                res_count  = total_reg;
            end
            default: begin
                phase_next = PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_HUNT0;
            max_length_reg <= MAX_LENGTH_RESET;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            len_low_reg    <= '0;
            total_reg      <= '0;
            count_reg      <= '0;
            cmd_reg        <= '0;
            sum_reg        <= '0;
            sum_low_reg    <= '0;
        end else begin
            if (cfg_wr_en) begin
                max_length_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                phase_reg     <= phase_next;
                len_low_reg   <= len_low_next;
                total_reg     <= total_next;
                count_reg     <= count_next;
                cmd_reg       <= cmd_next;
                sum_reg       <= sum_next;
                sum_low_reg   <= sum_low_next;
                out_valid_reg <= res_valid;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && res_valid) begin
            out_kind_reg  <= res_kind;
            out_data_reg  <= res_data;
            out_cmd_reg   <= res_cmd;
            out_count_reg <= res_count;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_kind          = out_kind_reg;
    assign m_data_byte     = out_data_reg;
    assign m_command       = out_cmd_reg;
    assign m_payload_count = out_count_reg;

`ifndef SYNTH
    a_payload_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_PAYLOAD) |-> (m_payload_count != '0))
        else $error("Payload transaction carries a zero byte count.");

    a_bad_len_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_BAD_LEN) |-> (m_command == '0 && m_payload_count == '0))
        else $error("Bad length verdict carries a nonzero command or count.");

    a_verdict_data_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_PAYLOAD) |-> (m_data_byte == '0))
        else $error("Verdict transaction carries a nonzero data byte.");

    a_payload_within_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PAYLOAD) |-> (count_reg < total_reg))
        else $error("Payload counter reached the frame length while still in payload.");
`endif

endmodule

`default_nettype wire

// ===== verif/sync_length_checksum_deframer_checker.sv =====
`timescale 1ns / 1ps
// Checker for sync_length_checksum_deframer: follows the byte and result channels
// and the max_length write port, predicts every result and compares them in order.
// Depends on slcd_pkg for the kind codes, sync bytes and field widths.
module sync_length_checksum_deframer_checker
    import slcd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [ByteW-1:0]  s_rx_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [KindW-1:0]  m_kind,
    input  logic [ByteW-1:0]  m_data_byte,
    input  logic [CmdW-1:0]   m_command,
    input  logic [CountW-1:0] m_payload_count,
    input  logic              cfg_wr_en,
    input  logic [CountW-1:0] cfg_wr_data,
    output int unsigned       fail_count,
    output int unsigned       outstanding,
    output int unsigned       payload_seen,
    output int unsigned       good_frames,
    output int unsigned       bad_sums,
    output int unsigned       bad_lengths
);

    typedef enum logic [3:0] {
        PH_HUNT0,
        PH_HUNT1,
        PH_LEN0,
        PH_LEN1,
        PH_LEN2,
        PH_LEN3,
        PH_CMD0,
        PH_CMD1,
        PH_PAYLOAD,
        PH_SUM0,
        PH_SUM1
    } parse_phase_t;

    typedef struct packed {
        kind_t             kind;
        logic [ByteW-1:0]  data;
        logic [CmdW-1:0]   command;
        logic [CountW-1:0] count;
    } deframe_result_t;

    localparam logic [31:0] OVERHEAD  = {10'd0, HEADER_BYTES};
    localparam int unsigned EXP_DEPTH = 16;

    deframe_result_t   exp_fifo[EXP_DEPTH];
    int unsigned       exp_wr;
    int unsigned       exp_rd;
    int unsigned       exp_count;
    parse_phase_t      phase;
    logic [CountW-1:0] length_limit;
    logic [31:0]       frame_len;
    logic [CountW-1:0] bytes_in_frame;
    logic [CmdW-1:0]   cmd_word;
    logic [SumW-1:0]   sum_acc;
    logic [ByteW-1:0]  sum_low;

    task automatic push_result(input kind_t k, input logic [ByteW-1:0] d,
                               input logic [CmdW-1:0] c, input logic [CountW-1:0] n);
        deframe_result_t r;
        r.kind    = k;
        r.data    = d;
        r.command = c;
        r.count   = n;
        exp_fifo[exp_wr] = r;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        exp_count++;
    endtask

    task automatic parse_byte(input logic [ByteW-1:0] b);
        case (phase)
            PH_HUNT0: begin
                if (b == SYNC_FIRST) phase = PH_HUNT1;
            end
            PH_HUNT1: begin
                if (b == SYNC_SECOND) phase = PH_LEN0;
                else if (b != SYNC_FIRST) phase = PH_HUNT0;
            end
            PH_LEN0: begin
                frame_len = {24'd0, b};
                phase = PH_LEN1;
            end
            PH_LEN1: begin
                frame_len[15:8] = b;
                phase = PH_LEN2;
            end
            PH_LEN2: begin
                frame_len[23:16] = b;
                phase = PH_LEN3;
            end
            PH_LEN3: begin
                frame_len[31:24] = b;
                if (frame_len < OVERHEAD || frame_len > {10'd0, length_limit}) begin
                    phase = PH_HUNT0;
                    push_result(KIND_BAD_LEN, '0, '0, '0);
                end else begin
                    phase = PH_CMD0;
                end
            end
            PH_CMD0: begin
                cmd_word = {8'd0, b};
                phase = PH_CMD1;
            end
            PH_CMD1: begin
                cmd_word[15:8] = b;
                bytes_in_frame = '0;
                sum_acc = '0;
                phase = (frame_len == OVERHEAD) ? PH_SUM0 : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                bytes_in_frame = bytes_in_frame + 1'b1;
                sum_acc = sum_acc + {8'd0, b};
                if ({10'd0, bytes_in_frame} >= frame_len - OVERHEAD) phase = PH_SUM0;
                push_result(KIND_PAYLOAD, b, cmd_word, bytes_in_frame);
            end
            PH_SUM0: begin
                sum_low = b;
                phase = PH_SUM1;
            end
            PH_SUM1: begin
                phase = PH_HUNT0;
                push_result(({b, sum_low} == sum_acc) ? KIND_GOOD : KIND_BAD_SUM, '0,
                            cmd_word, frame_len[CountW-1:0] - HEADER_BYTES);
            end
            default: phase = PH_HUNT0;
        endcase
    endtask

    always @(posedge aclk) begin : watch
        deframe_result_t got;
        deframe_result_t want;
        if (!aresetn) begin
            phase          = PH_HUNT0;
            length_limit   = MAX_LENGTH_RESET;
            frame_len      = '0;
            bytes_in_frame = '0;
            cmd_word       = '0;
            sum_acc        = '0;
            sum_low        = '0;
            exp_wr         = 0;
            exp_rd         = 0;
            exp_count      = 0;
            fail_count   <= 0;
            payload_seen <= 0;
            good_frames  <= 0;
            bad_sums     <= 0;
            bad_lengths  <= 0;
        end else begin
            if (cfg_wr_en) length_limit = cfg_wr_data;
            if (m_valid && m_ready) begin
                got.kind    = kind_t'(m_kind);
                got.data    = m_data_byte;
                got.command = m_command;
                got.count   = m_payload_count;
                if (exp_count == 0) begin
                    if (fail_count < 10)
                        $display("%0t: unexpected result kind %0d data %02h cmd %04h count %0d",
                                 $time, got.kind, got.data, got.command, got.count);
                    fail_count <= fail_count + 1;
                end else begin
                    want = exp_fifo[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_count--;
                    if (got.kind !== want.kind || got.data !== want.data ||
                        got.command !== want.command || got.count !== want.count) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch, expected kind %0d data %02h cmd %04h ",
                                      "count %0d, got kind %0d data %02h cmd %04h count %0d"},
                                     $time, want.kind, want.data, want.command, want.count,
                                     got.kind, got.data, got.command, got.count);
                        fail_count <= fail_count + 1;
                    end else begin
                        case (want.kind)
                            KIND_PAYLOAD: payload_seen <= payload_seen + 1;
                            KIND_GOOD:    good_frames  <= good_frames + 1;
                            KIND_BAD_SUM: bad_sums     <= bad_sums + 1;
                            default:      bad_lengths  <= bad_lengths + 1;
                        endcase
                    end
                end
            end
            if (s_valid && s_ready) parse_byte(s_rx_byte);
        end
        outstanding <= exp_count;
    end

endmodule

// ===== verif/sync_length_checksum_deframer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for sync_length_checksum_deframer: drives frames, noise and
// max_length settings with random stalls on both channels and gives the verdict.
// Depends on slcd_pkg, the block and sync_length_checksum_deframer_checker.
module sync_length_checksum_deframer_tb;
    import slcd_pkg::*;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              s_valid     = 1'b0;
    logic [ByteW-1:0]  s_rx_byte   = '0;
    logic              m_ready     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [CountW-1:0] cfg_wr_data = '0;
    logic              s_ready;
    logic              m_valid;
    logic [KindW-1:0]  m_kind;
    logic [ByteW-1:0]  m_data_byte;
    logic [CmdW-1:0]   m_command;
    logic [CountW-1:0] m_payload_count;

    int unsigned fail_count;
    int unsigned outstanding;
    int unsigned payload_seen;
    int unsigned good_frames;
    int unsigned bad_sums;
    int unsigned bad_lengths;

    logic              hold_req = 1'b0;
    logic              calm_tx  = 1'b0;
    logic              calm_rx  = 1'b0;
    int unsigned       bytes_sent = 0;
    logic [CountW-1:0] cur_max = MAX_LENGTH_RESET;

    sync_length_checksum_deframer uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_byte     (m_data_byte),
        .m_command       (m_command),
        .m_payload_count (m_payload_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    sync_length_checksum_deframer_checker frame_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_data_byte     (m_data_byte),
        .m_command       (m_command),
        .m_payload_count (m_payload_count),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .outstanding     (outstanding),
        .payload_seen    (payload_seen),
        .good_frames     (good_frames),
        .bad_sums        (bad_sums),
        .bad_lengths     (bad_lengths)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    initial begin : result_sink
        int unsigned wait_left;
        int unsigned held;
        wait_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (held = 0; held < 400; held++) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (wait_left > 0) begin
                m_ready <= 1'b0;
                wait_left--;
            end else begin
                m_ready <= 1'b1;
                if (!calm_rx) wait_left = pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [ByteW-1:0] b);
        int unsigned gap;
        s_valid <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
        gap = calm_tx ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_max(input logic [CountW-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        cur_max = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // A cut of zero sends the whole frame; otherwise only the first cut bytes go out.
    task automatic send_frame(input logic [31:0] len_field, input logic [CmdW-1:0] cmd,
                              input bit bad_sum, input int unsigned cut);
        logic [ByteW-1:0] frame[];
        logic [SumW-1:0]  sum;
        int unsigned      n_total;
        int unsigned      n_send;
        int unsigned      k;
        bit               len_ok;
        len_ok = (len_field >= {10'd0, HEADER_BYTES}) && (len_field <= {10'd0, cur_max});
        n_total = 6;
        if (len_ok) n_total = 6 + len_field;
        frame = new[n_total];
        frame[0] = SYNC_FIRST;
        frame[1] = SYNC_SECOND;
        frame[2] = len_field[7:0];
        frame[3] = len_field[15:8];
        frame[4] = len_field[23:16];
        frame[5] = len_field[31:24];
        if (len_ok) begin
            frame[6] = cmd[7:0];
            frame[7] = cmd[15:8];
            sum = '0;
            for (k = 8; k < n_total - 2; k++) begin
                frame[k] = ByteW'($urandom_range(0, 255));
                sum = sum + {8'd0, frame[k]};
            end
            if (bad_sum) sum = sum ^ SumW'($urandom_range(1, 65535));
            frame[n_total-2] = sum[7:0];
            frame[n_total-1] = sum[15:8];
        end
        n_send = (cut > 0 && cut < n_total) ? cut : n_total;
        for (k = 0; k < n_send; k++) send_byte(frame[k]);
    endtask

    task automatic random_traffic(input int unsigned n_bytes);
        int unsigned start;
        int unsigned r;
        int unsigned plen;
        int unsigned n;
        logic [31:0] len;
        logic [31:0] bad_len;
        logic [ByteW-1:0] noise;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            r = $urandom_range(0, 99);
            plen = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 150)
                                                : $urandom_range(0, 12);
            len = plen + 4;
            if (cur_max >= HEADER_BYTES && len > {10'd0, cur_max}) len = {10'd0, cur_max};
            if (r < 60) begin
                send_frame(len, CmdW'($urandom_range(0, 65535)), 1'b0, 0);
            end else if (r < 72) begin
                send_frame(len, CmdW'($urandom_range(0, 65535)), 1'b1, 0);
            end else if (r < 82) begin
                case ($urandom_range(0, 2))
                    0:       bad_len = $urandom_range(0, 3);
                    1:       bad_len = {10'd0, cur_max} + 1 + $urandom_range(0, 3);
                    default: begin
                        bad_len = $urandom;
                        if (bad_len <= {10'd0, cur_max}) bad_len = bad_len | 32'h8000_0000;
                    end
                endcase
                send_frame(bad_len, CmdW'($urandom_range(0, 65535)), 1'b0, 0);
            end else if (r < 90) begin
                send_frame(len, CmdW'($urandom_range(0, 65535)), 1'b0,
                           $urandom_range(1, 8 + plen));
            end else begin
                for (n = $urandom_range(1, 6); n > 0; n--) begin
                    case ($urandom_range(0, 3))
                        0:       noise = SYNC_FIRST;
                        1:       noise = SYNC_SECOND;
                        2:       noise = 8'h00;
                        default: noise = $urandom_range(0, 255);
                    endcase
                    send_byte(noise);
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [ByteW-1:0]  directed_bytes[];
        logic [CountW-1:0] max_settings[8];
        int unsigned       p;
        directed_bytes = '{
            8'h00, 8'hFF, 8'hFF, 8'hFE, 8'h04, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'hFF, 8'h00, 8'h00,
            8'hFF, 8'hFE, 8'h02, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'hFE, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
            8'hFF, 8'hFE, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00
        };
        max_settings = '{MAX_LENGTH_RESET, 22'd4, 22'd3, 22'd0, 22'h3FFFFF, 22'd37,
                         22'd300, 22'd0};
        max_settings[7] = CountW'($urandom_range(5, 500));
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        drain();

        for (p = 0; p < 8; p++) begin
            write_max(max_settings[p]);
            if (p == 6) begin
                calm_tx = 1'b1;
                hold_req = 1'b1;
            end
            if (p == 5) begin
                calm_tx = 1'b1;
                calm_rx = 1'b1;
            end
            random_traffic(250);
            calm_tx = 1'b0;
            calm_rx = 1'b0;
            drain();
        end

        $display("Run covered %0d input bytes under %0d max_length settings.",
                 bytes_sent, 8);
        $display("Checked %0d payload bytes, %0d good frames, %0d checksum errors, %0d %s",
                 payload_seen, good_frames, bad_sums, bad_lengths, "length errors.");
        if (fail_count == 0) begin
            $display("[sync_length_checksum_deframer] OK");
        end else begin
            $display("[sync_length_checksum_deframer] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #10ms;
        $display("[sync_length_checksum_deframer] ERROR");
        $finish;
    end

endmodule
